>>> design/i2ctbr_pkg.sv
// ----------------------------------------------------------------------------
// i2ctbr_pkg
// Shared types and constants for the i2c target byte receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package i2ctbr_pkg;

  localparam int unsigned AddrWidth = 7;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned BitIdxWidth = 3;

  localparam logic [AddrWidth-1:0] OwnAddrReset = 7'd8;
  localparam logic [BitIdxWidth-1:0] BitIdxMsb = 3'd7;
  localparam logic [BitIdxWidth-1:0] BitIdxLsb = 3'd0;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_AHIGH = 4'd1,
    PH_ALOW  = 4'd2,
    PH_K1A   = 4'd3,
    PH_K1B   = 4'd4,
    PH_K1C   = 4'd5,
    PH_DHIGH = 4'd6,
    PH_DLOW  = 4'd7,
    PH_K2A   = 4'd8,
    PH_K2B   = 4'd9
  } phase_e;

  typedef struct packed {
    logic                 sda_pull_low;
    logic                 activity;
    logic                 byte_valid;
    logic [ByteWidth-1:0] data_byte;
    logic                 address_mismatch;
  } result_t;

endpackage

`default_nettype wire

>>> design/i2c_target_byte_receiver_top.sv
// ----------------------------------------------------------------------------
// i2c_target_byte_receiver_top
// Pin-sampling i2c target that receives one addressed data byte per transfer.
// ----------------------------------------------------------------------------
// Usage: feed one sample of the scl/sda pin levels per cycle on the input
// valid/ready channel. Every sample yields exactly one result on the output
// valid/ready channel: the sda pull-low drive, the activity flag, a byte
// strobe with the received byte, and an address mismatch flag.
// Path: an accepted sample is held in the input register, then passes
// through the sequencer logic into the result register, from which the
// receiver takes it.
// Throughput: one sample per cycle, sustained while the output is taken.
// When the receiver stalls, the result register holds and the input register
// keeps one more sample; once both are full, in_ready_o drops. No sample is
// dropped or repeated.
// The own address register is written through cfg_we_i/cfg_wdata_i and must
// only change while the bus is idle.
// Reset (rst_ni low, asynchronous) puts the sequencer in idle with its ack
// state cleared, clears the pipeline valid flags and sets the own address to 8.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_target_byte_receiver_top
  import i2ctbr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 scl_level_i,
  input  wire logic                 sda_level_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      sda_pull_low_o,
  output logic                      activity_o,
  output logic                      byte_valid_o,
  output logic [ByteWidth-1:0]      data_byte_o,
  output logic                      address_mismatch_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [AddrWidth-1:0] cfg_wdata_i
);

  logic [AddrWidth-1:0] own_addr_q;
  logic                 s1_valid_q;
  logic                 s1_scl_q, s1_sda_q;
  logic                 out_valid_q;
  result_t              out_q;
  result_t              result;
  logic                 s1_adv;
  logic                 in_xfer;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= OwnAddrReset;
    end else if (cfg_we_i) begin
      own_addr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_scl_q <= scl_level_i;
      s1_sda_q <= sda_level_i;
    end
  end

  i2ctbr_fsm u_fsm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (s1_adv),
    .scl_i         (s1_scl_q),
    .sda_i         (s1_sda_q),
    .own_address_i (own_addr_q),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= result;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign sda_pull_low_o     = out_q.sda_pull_low;
  assign activity_o         = out_q.activity;
  assign byte_valid_o       = out_q.byte_valid;
  assign data_byte_o        = out_q.data_byte;
  assign address_mismatch_o = out_q.address_mismatch;

endmodule

`default_nettype wire

>>> design/i2ctbr_fsm.sv
// ----------------------------------------------------------------------------
// i2ctbr_fsm
// Receive sequencer: advances on one pin sample per step and builds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module i2ctbr_fsm
  import i2ctbr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic                 scl_i,
  input  wire logic                 sda_i,
  input  wire logic [AddrWidth-1:0] own_address_i,
  output result_t                   result_o
);

  phase_e                 phase_q, phase_d;
  logic [BitIdxWidth-1:0] bit_idx_q, bit_idx_d;
  logic [ByteWidth-1:0]   shift_q, shift_d;
  logic                   act_q, act_d;
  logic                   ack_q, ack_d;

  logic [ByteWidth-1:0]   shift_set;
  logic                   last_bit;

  // shift value with the current bit merged in
  always_comb begin
    shift_set = shift_q;
    if (sda_i) begin
      shift_set[bit_idx_q] = 1'b1;
    end
  end

  assign last_bit = (bit_idx_q == BitIdxLsb);

  // next state
  always_comb begin
    phase_d   = phase_q;
    bit_idx_d = bit_idx_q;
    shift_d   = shift_q;
    act_d     = act_q;
    ack_d     = ack_q;
    case (phase_q)
      PH_AHIGH, PH_DHIGH: begin
        if (scl_i) begin
          shift_d = shift_set;
          if (last_bit) begin
            if (phase_q == PH_AHIGH) begin
              if (shift_set[ByteWidth-1:1] != own_address_i) begin
                phase_d = PH_IDLE;
              end else begin
                act_d   = 1'b1;
                ack_d   = 1'b1;
                phase_d = PH_K1A;
              end
            end else begin
              ack_d   = 1'b1;
              phase_d = PH_K2A;
            end
          end else begin
            bit_idx_d = bit_idx_q - 1'b1;
            phase_d   = (phase_q == PH_AHIGH) ? PH_ALOW : PH_DLOW;
          end
        end
      end
      PH_ALOW: begin
        if (!scl_i) phase_d = PH_AHIGH;
      end
      PH_DLOW: begin
        if (!scl_i) phase_d = PH_DHIGH;
      end
      PH_K1A: begin
        if (!scl_i) phase_d = PH_K1B;
      end
      PH_K1B: begin
        if (scl_i) phase_d = PH_K1C;
      end
      PH_K1C: begin
        if (!scl_i) begin
          ack_d     = 1'b0;
          bit_idx_d = BitIdxMsb;
          shift_d   = '0;
          phase_d   = PH_DHIGH;
        end
      end
      PH_K2A: begin
        if (!scl_i) phase_d = PH_K2B;
      end
      PH_K2B: begin
        if (scl_i) begin
          ack_d   = 1'b0;
          phase_d = PH_IDLE;
        end
      end
      default: begin
        // idle and unused codes
        phase_d = PH_IDLE;
        if (!scl_i) begin
          bit_idx_d = BitIdxMsb;
          shift_d   = '0;
          phase_d   = PH_AHIGH;
        end else begin
          act_d = 1'b0;
        end
      end
    endcase
  end

  // result for this sample
  always_comb begin
    result_o.sda_pull_low     = ack_d;
    result_o.activity         = act_d;
    result_o.byte_valid       = 1'b0;
    result_o.data_byte        = '0;
    result_o.address_mismatch = 1'b0;
    case (phase_q)
      PH_AHIGH: begin
        result_o.address_mismatch = scl_i && last_bit &&
                                    (shift_set[ByteWidth-1:1] != own_address_i);
      end
      PH_K2B: begin
        if (scl_i) begin
          result_o.byte_valid = 1'b1;
          result_o.data_byte  = shift_q;
        end
      end
      default: begin
        result_o.address_mismatch = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      bit_idx_q <= BitIdxMsb;
      shift_q   <= '0;
      act_q     <= 1'b0;
      ack_q     <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      bit_idx_q <= bit_idx_d;
      shift_q   <= shift_d;
      act_q     <= act_d;
      ack_q     <= ack_d;
    end
  end

endmodule

`default_nettype wire

>>> design/i2ctbr_checker.sv
// ----------------------------------------------------------------------------
// i2ctbr_checker
// Port-level checks for the i2c target byte receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module i2ctbr_checker
  import i2ctbr_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire logic                 sda_pull_low_o,
  input wire logic                 activity_o,
  input wire logic                 byte_valid_o,
  input wire logic [ByteWidth-1:0] data_byte_o,
  input wire logic                 address_mismatch_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_byte_o) &&
      $stable(byte_valid_o) && $stable(sda_pull_low_o))
    else $error("stalled result changed");

  // a finished byte and a rejected address never share a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |-> !address_mismatch_o)
    else $error("byte strobe together with address mismatch");

  // data byte reads zero outside the byte strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> data_byte_o == '0)
    else $error("data byte nonzero without byte strobe");

  // sda is released when the address is rejected
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && address_mismatch_o |-> !sda_pull_low_o && !activity_o ||
      out_valid_o && address_mismatch_o && !sda_pull_low_o)
    else $error("sda driven on address mismatch");

  // sda is released on the clock that completes the byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |-> !sda_pull_low_o)
    else $error("sda still driven at byte completion");

endmodule

bind i2c_target_byte_receiver_top i2ctbr_checker u_i2ctbr_checker (.*);

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the i2c target byte receiver: drives scl/sda pin
// samples, predicts every result with a cycle model of the sequencer, and
// compares each result transfer field by field under random back-pressure.
// ----------------------------------------------------------------------------

module tb_top;
  import i2ctbr_pkg::*;

  localparam int StallLimit = 5000;
  localparam int DrainSettle = 4;
  localparam int SamplesPerPhase = 80;

  localparam result_t NoResult = '0;
  localparam result_t AddrMissResult = '{
    sda_pull_low: 1'b0, activity: 1'b0, byte_valid: 1'b0,
    data_byte: '0, address_mismatch: 1'b1
  };

  typedef struct packed {
    logic    scl;
    logic    sda;
    logic    pinned;
    result_t want;
  } pin_row_t;

  localparam int DirRows = 19;

  // idle samples, then a full address frame of all ones that must miss
  pin_row_t dir_rows [DirRows] = '{
    '{1'b1, 1'b1, 1'b1, NoResult},
    '{1'b1, 1'b0, 1'b1, NoResult},
    '{1'b0, 1'b1, 1'b0, NoResult},
    '{1'b1, 1'b1, 1'b0, NoResult}, '{1'b0, 1'b0, 1'b0, NoResult},
    '{1'b1, 1'b1, 1'b0, NoResult}, '{1'b0, 1'b0, 1'b0, NoResult},
    '{1'b1, 1'b1, 1'b0, NoResult}, '{1'b0, 1'b0, 1'b0, NoResult},
    '{1'b1, 1'b1, 1'b0, NoResult}, '{1'b0, 1'b0, 1'b0, NoResult},
    '{1'b1, 1'b1, 1'b0, NoResult}, '{1'b0, 1'b0, 1'b0, NoResult},
    '{1'b1, 1'b1, 1'b0, NoResult}, '{1'b0, 1'b0, 1'b0, NoResult},
    '{1'b1, 1'b1, 1'b0, NoResult}, '{1'b0, 1'b0, 1'b0, NoResult},
    '{1'b1, 1'b1, 1'b1, AddrMissResult},
    '{1'b1, 1'b0, 1'b1, NoResult}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 scl_level_i;
  logic                 sda_level_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 sda_pull_low_o;
  logic                 activity_o;
  logic                 byte_valid_o;
  logic [ByteWidth-1:0] data_byte_o;
  logic                 address_mismatch_o;
  logic                 cfg_we_i;
  logic [AddrWidth-1:0] cfg_wdata_i;

  i2c_target_byte_receiver_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .scl_level_i        (scl_level_i),
    .sda_level_i        (sda_level_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .sda_pull_low_o     (sda_pull_low_o),
    .activity_o         (activity_o),
    .byte_valid_o       (byte_valid_o),
    .data_byte_o        (data_byte_o),
    .address_mismatch_o (address_mismatch_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  // sequencer model state
  phase_e                 seq_phase;
  logic [BitIdxWidth-1:0] seq_bit;
  logic [ByteWidth-1:0]   seq_shift;
  logic                   seq_active;
  logic                   seq_ack;
  logic [AddrWidth-1:0]   own_addr_model;

  result_t bus_result_q [$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int quiet_cycles;
  int check_failures;
  int samples_sent;
  int bytes_seen;
  int misses_seen;
  int cfg_writes;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic result_t predict_pin_sample(logic scl, logic sda);
    result_t r;
    r = NoResult;
    case (seq_phase)
      PH_AHIGH, PH_DHIGH: begin
        if (scl) begin
          if (sda) seq_shift[seq_bit] = 1'b1;
          if (seq_bit == BitIdxLsb) begin
            if (seq_phase == PH_AHIGH) begin
              if (seq_shift[ByteWidth-1:1] != own_addr_model) begin
                r.address_mismatch = 1'b1;
                seq_phase = PH_IDLE;
              end else begin
                seq_active = 1'b1;
                seq_ack = 1'b1;
                seq_phase = PH_K1A;
              end
            end else begin
              seq_ack = 1'b1;
              seq_phase = PH_K2A;
            end
          end else begin
            seq_bit = seq_bit - 1'b1;
            if (seq_phase == PH_AHIGH) seq_phase = PH_ALOW;
            else seq_phase = PH_DLOW;
          end
        end
      end
      PH_ALOW: if (!scl) seq_phase = PH_AHIGH;
      PH_DLOW: if (!scl) seq_phase = PH_DHIGH;
      PH_K1A:  if (!scl) seq_phase = PH_K1B;
      PH_K1B:  if (scl) seq_phase = PH_K1C;
      PH_K1C: begin
        if (!scl) begin
          seq_ack = 1'b0;
          seq_bit = BitIdxMsb;
          seq_shift = '0;
          seq_phase = PH_DHIGH;
        end
      end
      PH_K2A:  if (!scl) seq_phase = PH_K2B;
      PH_K2B: begin
        if (scl) begin
          seq_ack = 1'b0;
          r.byte_valid = 1'b1;
          r.data_byte = seq_shift;
          seq_phase = PH_IDLE;
        end
      end
      default: begin
        seq_phase = PH_IDLE;
        if (!scl) begin
          seq_bit = BitIdxMsb;
          seq_shift = '0;
          seq_phase = PH_AHIGH;
        end else begin
          seq_active = 1'b0;
        end
      end
    endcase
    r.sda_pull_low = seq_ack;
    r.activity = seq_active;
    return r;
  endfunction

  // offer one pin sample; returns in the time step of its transfer
  task automatic send_sample(input logic scl, input logic sda, input logic pinned,
                             input result_t literal);
    result_t predicted;
    @(negedge clk_i);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    scl_level_i <= scl;
    sda_level_i <= sda;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = predict_pin_sample(scl, sda);
    bus_result_q.push_back(pinned ? literal : predicted);
    samples_sent++;
  endtask

  // clock one bus transfer through until the sequencer is back in idle,
  // holding each line level for a random number of samples
  task automatic run_transfer(input logic [ByteWidth-1:0] addr_frame,
                              input logic [ByteWidth-1:0] payload);
    bit   started;
    logic scl;
    logic sda;
    started = 1'b0;
    while (!(started && seq_phase == PH_IDLE)) begin
      case (seq_phase)
        PH_AHIGH, PH_DHIGH, PH_K1B, PH_K2B: scl = 1'b1;
        default: scl = 1'b0;
      endcase
      sda = 1'($urandom_range(1));
      if ($urandom_range(3) == 0) scl = ~scl;
      else if (seq_phase == PH_AHIGH) sda = addr_frame[seq_bit];
      else if (seq_phase == PH_DHIGH) sda = payload[seq_bit];
      send_sample(scl, sda, 1'b0, NoResult);
      if (seq_phase != PH_IDLE) started = 1'b1;
    end
  endtask

  task automatic settle_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (bus_result_q.size() != 0) @(posedge clk_i);
    repeat (DrainSettle) @(posedge clk_i);
  endtask

  task automatic write_own_address(input logic [AddrWidth-1:0] addr);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= addr;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    own_addr_model = addr;
    cfg_writes++;
  endtask

  task automatic compare_field(input string name, input logic [ByteWidth-1:0] want,
                               input logic [ByteWidth-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      check_failures++;
    end
  endtask

  // receiver side, with an optional long hold-off
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (bus_result_q.size() == 0) begin
        $error("result transfer with no sample outstanding");
        check_failures++;
      end else begin
        want = bus_result_q.pop_front();
        compare_field("sda_pull_low", want.sda_pull_low, sda_pull_low_o);
        compare_field("activity", want.activity, activity_o);
        compare_field("byte_valid", want.byte_valid, byte_valid_o);
        compare_field("data_byte", want.data_byte, data_byte_o);
        compare_field("address_mismatch", want.address_mismatch, address_mismatch_o);
        if (want.byte_valid) bytes_seen++;
        if (want.address_mismatch) misses_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles == StallLimit) begin
        $display("[i2c_target_byte_receiver_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [AddrWidth-1:0] target_addr;
    logic [ByteWidth-1:0] data_pick;
    logic                 rw_bit;
    int                   phase_goal;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    scl_level_i    = 1'b1;
    sda_level_i    = 1'b1;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    hold_cycles    = 0;
    quiet_cycles   = 0;
    check_failures = 0;
    samples_sent   = 0;
    bytes_seen     = 0;
    misses_seen    = 0;
    cfg_writes     = 0;
    seq_phase      = PH_IDLE;
    seq_bit        = BitIdxMsb;
    seq_shift      = '0;
    seq_active     = 1'b0;
    seq_ack        = 1'b0;
    own_addr_model = OwnAddrReset;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send_sample(dir_rows[i].scl, dir_rows[i].sda, dir_rows[i].pinned, dir_rows[i].want);
    end
    // matched transfers at the reset address, write then read bit, with the byte extremes
    run_transfer({own_addr_model, 1'b0}, 8'hFF);
    run_transfer({own_addr_model, 1'b1}, 8'h00);

    for (int p = 0; p < 6; p++) begin
      settle_results();
      case (p)
        0: write_own_address(7'h00);
        1: write_own_address(7'h7F);
        3: write_own_address(7'h55);
        4: write_own_address(7'h2A);
        default: write_own_address(7'($urandom_range(127)));
      endcase
      case (p / 2)
        0: begin send_idle_pct = 9;  recv_idle_pct = 86; end
        1: begin send_idle_pct = 86; recv_idle_pct = 9;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      // receiver stops long enough for the pipeline to back up into the input
      if (p == 4) hold_cycles = 64;
      phase_goal = samples_sent + SamplesPerPhase;
      while (samples_sent < phase_goal) begin
        if ($urandom_range(4) == 0) begin
          repeat ($urandom_range(1, 5)) begin
            send_sample(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, NoResult);
          end
        end else begin
          target_addr = ($urandom_range(3) != 0) ? own_addr_model
                                                 : 7'($urandom_range(127));
          rw_bit = 1'($urandom_range(1));
          case ($urandom_range(3))
            0: data_pick = 8'h00;
            1: data_pick = 8'hFF;
            default: data_pick = 8'($urandom_range(255));
          endcase
          run_transfer({target_addr, rw_bit}, data_pick);
        end
      end
      // leave the bus idle before the address changes
      if (seq_phase != PH_IDLE) begin
        run_transfer(8'($urandom_range(255)), 8'($urandom_range(255)));
      end
    end

    settle_results();
    repeat (8) @(posedge clk_i);

    $display("pin samples: %0d, bytes received: %0d, address misses: %0d",
             samples_sent, bytes_seen, misses_seen);
    $display("own address writes: %0d, under three handshake pacing modes",
             cfg_writes);
    if (check_failures == 0) begin
      $display("[i2c_target_byte_receiver_top] OK");
    end else begin
      $display("[i2c_target_byte_receiver_top] ERROR");
    end
    $finish;
  end

endmodule
